// File: rtl/xues_pkg.sv
// ============================================================================
// xues_pkg: shared types and constants of the entity unescape stream
// Item and state types, character codes and the byte classifiers.
// ============================================================================
package xues_pkg;

    typedef logic [7:0] t_byte;

    // Class of a raw input byte, as the front end tags it
    typedef enum logic [1:0] {
        K_TEXT,
        K_AMP,
        K_SEMI
    } t_kind;

    // One queued input transfer
    typedef struct packed {
        t_byte data;
        logic  last;
        t_kind kind;
    } t_item;

    // Back end sequencer
    typedef enum logic [2:0] {
        S_IDLE,
        S_RESCAN,
        S_FLUSH,
        S_RESOLVE,
        S_RAW
    } t_state;

    // Number parser phases (strtol style)
    typedef enum logic [2:0] {
        P_HASH,
        P_BASE,
        P_WS,
        P_LEAD,
        P_ZERO,
        P_ZEROX,
        P_DIGITS,
        P_DONE
    } t_phase;

    typedef struct packed {
        logic       ok;
        logic [3:0] val;
    } t_digit;

    localparam t_byte CH_AMP     = 8'h26;
    localparam t_byte CH_SEMI    = 8'h3B;
    localparam t_byte CH_HASH    = 8'h23;
    localparam t_byte CH_PLUS    = 8'h2B;
    localparam t_byte CH_MINUS   = 8'h2D;
    localparam t_byte CH_LOWER_X = 8'h78;
    localparam t_byte CH_UPPER_X = 8'h58;
    localparam t_byte CH_SPACE   = 8'h20;
    localparam t_byte CH_SUBST   = 8'h3F;

    // Positive codes below this limit come out as the byte itself
    localparam logic [7:0]  LOW_CODE_LIMIT = 8'h80;
    // Largest magnitude a conversion may reach (negative side only)
    localparam logic [63:0] MAG_LIMIT      = 64'h8000_0000_0000_0000;

    // Named entities: lt, gt, amp, quot, apos
    localparam int NAME_NUM = 5;
    localparam int NAME_MAX = 4;
    localparam t_byte NAME_CHR [NAME_NUM][NAME_MAX] = '{
        '{8'h6C, 8'h74, 8'h00, 8'h00},
        '{8'h67, 8'h74, 8'h00, 8'h00},
        '{8'h61, 8'h6D, 8'h70, 8'h00},
        '{8'h71, 8'h75, 8'h6F, 8'h74},
        '{8'h61, 8'h70, 8'h6F, 8'h73}
    };
    localparam logic [2:0] NAME_LEN [NAME_NUM] = '{3'd2, 3'd2, 3'd3, 3'd4, 3'd4};
    localparam t_byte NAME_OUT [NAME_NUM] = '{8'h3C, 8'h3E, 8'h26, 8'h22, 8'h27};

    function automatic t_kind classify(input t_byte b);
        t_kind k;
        case (b)
            CH_AMP:  k = K_AMP;
            CH_SEMI: k = K_SEMI;
            default: k = K_TEXT;
        endcase
        return k;
    endfunction

    function automatic logic is_space(input t_byte b);
        return (b inside {CH_SPACE, [8'h09:8'h0D]});
    endfunction

    function automatic logic is_sign(input t_byte b);
        return (b == CH_PLUS) || (b == CH_MINUS);
    endfunction

    function automatic logic is_x(input t_byte b);
        return (b == CH_LOWER_X) || (b == CH_UPPER_X);
    endfunction

    function automatic t_digit digit_of(input t_byte b, input logic hex);
        t_digit d;
        d.ok  = 1'b0;
        d.val = 4'd0;
        if (b inside {[8'h30:8'h39]}) begin
            d.ok  = 1'b1;
            d.val = 4'(b - 8'h30);
        end else if (hex && (b inside {[8'h61:8'h66]})) begin
            d.ok  = 1'b1;
            d.val = 4'(b - 8'h57);
        end else if (hex && (b inside {[8'h41:8'h46]})) begin
            d.ok  = 1'b1;
            d.val = 4'(b - 8'h37);
        end
        return d;
    endfunction

endpackage

// File: rtl/xues_in_if.sv
// ============================================================================
// xues_in_if: escaped text channel
// Valid/ready channel carrying one raw text byte per transfer.
// ============================================================================
interface xues_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] in_byte;
    logic       in_last;

    modport source (output valid, output in_byte, output in_last, input ready);
    modport sink   (input valid, input in_byte, input in_last, output ready);
endinterface

// File: rtl/xues_out_if.sv
// ============================================================================
// xues_out_if: unescaped text channel
// Valid/ready channel carrying one decoded byte per transfer.
// ============================================================================
interface xues_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic       out_last;

    modport source (output valid, output out_byte, output out_last, input ready);
    modport sink   (input valid, input out_byte, input out_last, output ready);
endinterface

// File: rtl/xues_front.sv
// ============================================================================
// xues_front: input classifier
// Tags each incoming byte as ampersand, semicolon or plain text.
// ============================================================================
module xues_front (
    xues_in_if.sink         i_text,
    output xues_pkg::t_item o_item,
    output logic            o_item_valid,
    input  logic            i_item_ready
);
    import xues_pkg::*;

    assign i_text.ready  = i_item_ready;
    assign o_item_valid  = i_text.valid;
    assign o_item.data   = i_text.in_byte;
    assign o_item.last   = i_text.in_last;
    assign o_item.kind   = classify(i_text.in_byte);

endmodule

// File: rtl/xues_queue.sv
// ============================================================================
// xues_queue: item queue between front and back end
// Small circular buffer; full and empty come from an occupancy count.
// ============================================================================
module xues_queue #(
    parameter int DEPTH = 2
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  xues_pkg::t_item i_push_item,
    input  logic            i_push_valid,
    output logic            o_push_ready,
    output xues_pkg::t_item o_pop_item,
    output logic            o_pop_valid,
    input  logic            i_pop_ready
);
    import xues_pkg::*;

    localparam int PW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    t_item          r_mem [DEPTH];
    logic [PW-1:0]  r_wp;
    logic [PW-1:0]  r_rp;
    logic [CW-1:0]  r_count;
    logic           push;
    logic           pop;

    assign o_push_ready = (r_count != CW'(DEPTH));
    assign o_pop_valid  = (r_count != '0);
    assign o_pop_item   = r_mem[r_rp];
    assign push         = i_push_valid && o_push_ready;
    assign pop          = o_pop_valid && i_pop_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp    <= '0;
            r_rp    <= '0;
            r_count <= '0;
        end else begin
            if (push) begin
                r_wp <= (r_wp == PW'(DEPTH - 1)) ? '0 : r_wp + PW'(1);
            end
            if (pop) begin
                r_rp <= (r_rp == PW'(DEPTH - 1)) ? '0 : r_rp + PW'(1);
            end
            if (push && !pop) begin
                r_count <= r_count + CW'(1);
            end else if (pop && !push) begin
                r_count <= r_count - CW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wp] <= i_push_item;
        end
    end

endmodule

// File: rtl/xues_back.sv
// ============================================================================
// xues_back: entity engine
// Holds pending entities, resolves them one byte per cycle and drives the
// output register.
// ============================================================================
module xues_back #(
    parameter int MAX_ENTITY_SPAN = 10
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  xues_pkg::t_item i_item,
    input  logic            i_item_valid,
    output logic            o_item_ready,
    xues_out_if.source      o_text
);
    import xues_pkg::*;

    localparam int IW = $clog2(MAX_ENTITY_SPAN);
    localparam int CW = $clog2(MAX_ENTITY_SPAN + 1);
    localparam logic [CW-1:0] SPAN = CW'(MAX_ENTITY_SPAN);

    // Sequencer and hold buffer
    t_state         r_state, n_state;
    logic [CW-1:0]  r_cnt, n_cnt;
    logic [CW-1:0]  r_idx, n_idx;
    t_byte          r_pend, n_pend;
    logic           r_last, n_last;
    t_byte          r_held [MAX_ENTITY_SPAN];

    // Parser and name match
    t_phase                r_phase, n_phase;
    logic                  r_hex, n_hex;
    logic                  r_neg, n_neg;
    logic                  r_any, n_any;
    logic                  r_ovf, n_ovf;
    logic [63:0]           r_mag, n_mag;
    logic [NAME_NUM-1:0]   r_name_ok, n_name_ok;

    // Output register
    logic  r_out_valid;
    t_byte r_out_byte;
    logic  r_out_last;

    logic          out_free;
    logic          advance;
    logic          emit;
    t_byte         e_byte;
    logic          e_last;
    logic          w_en;
    logic [IW-1:0] w_idx;
    t_byte         w_data;
    t_byte         rd_byte;
    t_byte         sel_byte;
    logic          at_pend;

    // Per-byte parser step
    t_phase              ph;
    logic                hx;
    logic                skip;
    t_digit              dig;
    logic [67:0]         grow;
    logic                big;
    t_phase              p_phase;
    logic                p_hex, p_neg, p_any, p_ovf;
    logic [63:0]         p_mag;
    logic [NAME_NUM-1:0] p_name_ok;
    logic [CW-1:0]       pos;

    // Resolution result
    logic  name_hit;
    t_byte name_char;
    logic  num_ok;
    t_byte code_char;

    assign out_free = !r_out_valid || o_text.ready;
    assign rd_byte  = r_held[r_idx[IW-1:0]];
    assign at_pend  = (r_idx == SPAN);
    assign sel_byte = at_pend ? r_pend : rd_byte;

    assign o_text.valid    = r_out_valid;
    assign o_text.out_byte = r_out_byte;
    assign o_text.out_last = r_out_last;

    // strtol-style step on the held byte at r_idx
    always_comb begin
        ph      = r_phase;
        hx      = r_hex;
        skip    = 1'b0;
        p_phase = r_phase;
        p_neg   = r_neg;
        p_any   = r_any;
        p_ovf   = r_ovf;
        p_mag   = r_mag;
        if (ph == P_HASH) begin
            p_phase = (rd_byte == CH_HASH) ? P_BASE : P_DONE;
            skip    = 1'b1;
        end else if (ph == P_BASE) begin
            if (is_x(rd_byte)) begin
                hx      = 1'b1;
                p_phase = P_WS;
                skip    = 1'b1;
            end else begin
                hx = 1'b0;
                ph = P_WS;
            end
        end
        if (!skip && ph == P_WS && !is_space(rd_byte) && !is_sign(rd_byte)) begin
            ph = P_LEAD;
        end
        dig  = digit_of(rd_byte, hx);
        grow = (hx ? {r_mag, 4'b0000}
                   : (({4'b0000, r_mag} << 3) + ({4'b0000, r_mag} << 1)))
               + 68'(dig.val);
        big  = (grow > {4'b0000, MAG_LIMIT});
        if (!skip) begin
            case (ph)
                P_WS: begin
                    if (is_sign(rd_byte)) begin
                        p_neg   = (rd_byte == CH_MINUS);
                        p_phase = P_LEAD;
                    end else begin
                        p_phase = P_WS;
                    end
                end
                P_LEAD, P_ZERO, P_ZEROX, P_DIGITS: begin
                    if (ph == P_ZERO && is_x(rd_byte)) begin
                        p_phase = P_ZEROX;
                    end else if (dig.ok) begin
                        p_any = 1'b1;
                        if (!r_ovf) begin
                            if (big) begin
                                p_ovf = 1'b1;
                            end else begin
                                p_mag = grow[63:0];
                            end
                        end
                        // a lone leading zero in hex may still open a 0x prefix
                        p_phase = (ph == P_LEAD && hx && dig.val == 4'd0) ? P_ZERO : P_DIGITS;
                    end else begin
                        p_phase = P_DONE;
                    end
                end
                default: begin
                    p_phase = r_phase;
                end
            endcase
        end
        p_hex = hx;
    end

    // Name match, one position per cycle
    always_comb begin
        pos = r_idx - CW'(1);
        for (int i = 0; i < NAME_NUM; i++) begin
            p_name_ok[i] = r_name_ok[i] && (pos < CW'(NAME_LEN[i]))
                           && (rd_byte == NAME_CHR[i][pos[1:0]]);
        end
    end

    always_comb begin
        name_hit  = 1'b0;
        name_char = CH_SUBST;
        for (int i = 0; i < NAME_NUM; i++) begin
            if (r_name_ok[i] && (r_cnt == CW'(NAME_LEN[i]) + CW'(1))) begin
                name_hit  = 1'b1;
                name_char = NAME_OUT[i];
            end
        end
        num_ok    = r_any && !r_ovf && !(!r_neg && r_mag == MAG_LIMIT);
        code_char = (!r_neg && r_mag != 64'd0 && r_mag < 64'(LOW_CODE_LIMIT))
                    ? t_byte'(r_mag[7:0]) : CH_SUBST;
    end

    // Sequencer: next state and outputs
    always_comb begin
        n_state   = r_state;
        n_cnt     = r_cnt;
        n_idx     = r_idx;
        n_pend    = r_pend;
        n_last    = r_last;
        n_phase   = r_phase;
        n_hex     = r_hex;
        n_neg     = r_neg;
        n_any     = r_any;
        n_ovf     = r_ovf;
        n_mag     = r_mag;
        n_name_ok = r_name_ok;
        emit      = 1'b0;
        e_byte    = CH_SUBST;
        e_last    = 1'b0;
        w_en      = 1'b0;
        w_idx     = '0;
        w_data    = i_item.data;
        case (r_state)
            S_IDLE: begin
                if (i_item_valid && out_free) begin
                    if (r_cnt == '0) begin
                        if (i_item.kind == K_AMP && !i_item.last) begin
                            w_en  = 1'b1;
                            n_cnt = CW'(1);
                        end else begin
                            emit   = 1'b1;
                            e_byte = i_item.data;
                            e_last = i_item.last;
                        end
                    end else if (i_item.kind == K_SEMI) begin
                        n_last    = i_item.last;
                        n_idx     = CW'(1);
                        n_phase   = P_HASH;
                        n_hex     = 1'b0;
                        n_neg     = 1'b0;
                        n_any     = 1'b0;
                        n_ovf     = 1'b0;
                        n_mag     = '0;
                        n_name_ok = '1;
                        n_state   = S_RESOLVE;
                    end else if (r_cnt < SPAN) begin
                        w_en  = 1'b1;
                        w_idx = r_cnt[IW-1:0];
                        n_cnt = r_cnt + CW'(1);
                        if (i_item.last) begin
                            n_idx   = '0;
                            n_state = S_FLUSH;
                        end
                    end else begin
                        // window ran out: give up the '&' and rescan the rest
                        emit    = 1'b1;
                        e_byte  = CH_AMP;
                        n_pend  = i_item.data;
                        n_last  = i_item.last;
                        n_cnt   = '0;
                        n_idx   = CW'(1);
                        n_state = S_RESCAN;
                    end
                end
            end
            S_RESCAN: begin
                w_data = sel_byte;
                if (r_cnt != '0) begin
                    w_en  = 1'b1;
                    w_idx = r_cnt[IW-1:0];
                    n_cnt = r_cnt + CW'(1);
                end else if (classify(sel_byte) == K_AMP) begin
                    w_en  = 1'b1;
                    n_cnt = CW'(1);
                end else begin
                    emit   = 1'b1;
                    e_byte = sel_byte;
                    e_last = r_last && at_pend;
                end
                if (at_pend) begin
                    n_idx   = '0;
                    n_state = (r_last && n_cnt != '0) ? S_FLUSH : S_IDLE;
                end else begin
                    n_idx = r_idx + CW'(1);
                end
            end
            S_FLUSH: begin
                emit   = 1'b1;
                e_byte = rd_byte;
                e_last = (r_idx == r_cnt - CW'(1));
                if (e_last) begin
                    n_cnt   = '0;
                    n_state = S_IDLE;
                end else begin
                    n_idx = r_idx + CW'(1);
                end
            end
            S_RESOLVE: begin
                if (r_idx == r_cnt) begin
                    if (name_hit || num_ok) begin
                        emit    = 1'b1;
                        e_byte  = name_hit ? name_char : code_char;
                        e_last  = r_last;
                        n_cnt   = '0;
                        n_state = S_IDLE;
                    end else begin
                        n_idx   = '0;
                        n_state = S_RAW;
                    end
                end else begin
                    n_phase   = p_phase;
                    n_hex     = p_hex;
                    n_neg     = p_neg;
                    n_any     = p_any;
                    n_ovf     = p_ovf;
                    n_mag     = p_mag;
                    n_name_ok = p_name_ok;
                    n_idx     = r_idx + CW'(1);
                end
            end
            S_RAW: begin
                emit = 1'b1;
                if (r_idx == r_cnt) begin
                    e_byte  = CH_SEMI;
                    e_last  = r_last;
                    n_cnt   = '0;
                    n_state = S_IDLE;
                end else begin
                    e_byte = rd_byte;
                    n_idx  = r_idx + CW'(1);
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign advance      = !emit || out_free;
    assign o_item_ready = (r_state == S_IDLE) && out_free;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_cnt       <= '0;
            r_idx       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (advance) begin
                r_state <= n_state;
                r_cnt   <= n_cnt;
                r_idx   <= n_idx;
            end
            if (advance && emit) begin
                r_out_valid <= 1'b1;
            end else if (o_text.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_pend    <= n_pend;
            r_last    <= n_last;
            r_phase   <= n_phase;
            r_hex     <= n_hex;
            r_neg     <= n_neg;
            r_any     <= n_any;
            r_ovf     <= n_ovf;
            r_mag     <= n_mag;
            r_name_ok <= n_name_ok;
        end
        if (advance && emit) begin
            r_out_byte <= e_byte;
            r_out_last <= e_last;
        end
        if (advance && w_en) begin
            r_held[w_idx] <= w_data;
        end
    end

endmodule

// File: rtl/xml_entity_unescape_stream.sv
// ============================================================================
// xml_entity_unescape_stream: streaming XML character entity decoder
// Front classifier, item queue and entity engine.
// ============================================================================
// Usage
//   i_text carries escaped text, one byte per transfer, in_last on the final
//   byte of a text. o_text carries the decoded bytes, out_last on the final
//   decoded byte of that text. Plain bytes flow at one per cycle while the
//   receiver does not stall; each passes through the queue and then the
//   output register.
//   A '&' and up to MAX_ENTITY_SPAN-1 bytes after it are held inside the
//   engine with no output, one per cycle while the output register is free.
//   On ';' the engine walks the held bytes, one per cycle, then emits one
//   decoded byte, or else the raw copy at one byte per cycle while the
//   receiver takes it (len+2 bytes, len = bytes between '&' and ';').
//   A window that fills without ';' gives up the '&' and rescans the rest;
//   end of text with a pending entity flushes the held bytes out raw.
//   While the engine is busy the two-entry queue keeps taking input, so
//   i_text.ready only drops once the queue is full.
//   A receiver stall holds the output register; the engine waits on its next
//   emitted byte and the queue then fills behind it.
//   Reset (synchronous, active low) empties the queue and the output
//   register and drops any pending entity.
// ============================================================================
module xml_entity_unescape_stream #(
    parameter int MAX_ENTITY_SPAN = 10
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    xues_in_if.sink    i_text,
    xues_out_if.source o_text
);
    import xues_pkg::*;

    localparam int QUEUE_DEPTH = 2;

    // front -> queue
    t_item push_item;
    logic  push_valid;
    logic  push_ready;
    // queue -> engine
    t_item pop_item;
    logic  pop_valid;
    logic  pop_ready;

    // Classify each byte as it transfers in
    xues_front u_front (
        .i_text       (i_text),
        .o_item       (push_item),
        .o_item_valid (push_valid),
        .i_item_ready (push_ready)
    );

    // Decouples input from the multi-cycle entity work
    xues_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push_item  (push_item),
        .i_push_valid (push_valid),
        .o_push_ready (push_ready),
        .o_pop_item   (pop_item),
        .o_pop_valid  (pop_valid),
        .i_pop_ready  (pop_ready)
    );

    // Hold, resolve and emit; drives the registered output
    xues_back #(
        .MAX_ENTITY_SPAN (MAX_ENTITY_SPAN)
    ) u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_item       (pop_item),
        .i_item_valid (pop_valid),
        .o_item_ready (pop_ready),
        .o_text       (o_text)
    );

endmodule

// File: rtl/xues_checker.sv
// ============================================================================
// xues_checker: port-level checks for the entity unescape stream
// Output channel behavior and reset state, seen from the top level ports.
// ============================================================================
module xues_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_in_ready,
    input logic       i_out_valid,
    input logic       i_out_ready,
    input logic [7:0] i_out_byte,
    input logic       i_out_last
);

    // a pending output transfer is not withdrawn
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid)
        else $error("output valid dropped while stalled");

    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> $stable(i_out_byte) && $stable(i_out_last))
        else $error("output payload changed while stalled");

    // queue comes out of reset empty
    a_in_ready_reset: assert property (@(posedge i_clk)
        i_rst_n && $past(!i_rst_n) |-> i_in_ready)
        else $error("input not ready right after reset");

    // nothing left in the output register after reset
    a_out_idle_reset: assert property (@(posedge i_clk)
        i_rst_n && $past(!i_rst_n) |-> !i_out_valid)
        else $error("output valid right after reset");

endmodule

bind xml_entity_unescape_stream xues_checker u_xues_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_ready  (i_text.ready),
    .i_out_valid (o_text.valid),
    .i_out_ready (o_text.ready),
    .i_out_byte  (o_text.out_byte),
    .i_out_last  (o_text.out_last)
);
